/* src/u8ve_pkg.sv */
// Shared types, constants and helpers for the UTF-8 validate-and-escape block.
package u8ve_pkg;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Byte classification limits
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_LOW    = 8'hC2;
    localparam logic [7:0] LEAD3_LOW    = 8'hE0;
    localparam logic [7:0] LEAD4_LOW    = 8'hF0;
    localparam logic [7:0] LEAD_LIMIT   = 8'hF5;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_TAG     = 8'h80;
    localparam logic [7:0] LEAD_E0      = 8'hE0;
    localparam logic [7:0] LEAD_ED      = 8'hED;
    localparam logic [7:0] LEAD_F0      = 8'hF0;
    localparam logic [7:0] LEAD_F4      = 8'hF4;
    localparam logic [7:0] SURR_LIMIT   = 8'hA0;
    localparam logic [7:0] PLANE_LIMIT  = 8'h90;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    // Escape characters
    localparam logic [7:0] CHR_BSLASH   = 8'h5C;
    localparam logic [7:0] CHR_X        = 8'h78;
    localparam logic [7:0] CHR_ZERO     = 8'h30;
    localparam logic [7:0] CHR_ALPHA    = 8'h37;   // 'A' - 10

    // Position within a four-character escape
    localparam logic [1:0] ESC_BSLASH   = 2'd0;
    localparam logic [1:0] ESC_X        = 2'd1;
    localparam logic [1:0] ESC_HI       = 2'd2;
    localparam logic [1:0] ESC_LO       = 2'd3;

    // What happens to the incoming byte in one command
    typedef enum logic [1:0] {
        B_NONE,
        B_PASS,
        B_ESC
    } t_bmode;

    // One command word: held prefix (pass or escape), then the incoming byte
    typedef struct packed {
        logic [2:0][7:0] held;
        logic [1:0]      pfx_n;
        logic            pfx_esc;
        logic [7:0]      b;
        t_bmode          bmode;
        logic            eos;
    } t_cmd;

    // Upper-case hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (CHR_ZERO + {4'd0, d}) : (CHR_ALPHA + {4'd0, d});
    endfunction

    // Sequence length from a lead byte, 0 for a byte that cannot lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        if (b < ASCII_LIMIT) return 3'd1;
        if (b < LEAD2_LOW)   return 3'd0;
        if (b < LEAD3_LOW)   return 3'd2;
        if (b < LEAD4_LOW)   return 3'd3;
        if (b < LEAD_LIMIT)  return 3'd4;
        return 3'd0;
    endfunction

endpackage

/* src/u8ve_front.sv */
// Front end: takes input bytes, tracks the held UTF-8 sequence, issues command words.
module u8ve_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_string,
    input  logic          i_q_full,
    output logic          o_push,
    output u8ve_pkg::t_cmd o_cmd
);
    import u8ve_pkg::*;

    logic [2:0][7:0] r_held;
    logic [1:0]      r_cnt;
    logic [2:0]      r_exp;
    logic [1:0]      n_cnt;
    logic [2:0]      n_exp;
    logic            hold_we;
    logic [1:0]      hold_idx;
    logic            accept;
    logic            ok;
    logic            complete;
    logic            take_idle;
    logic [2:0]      len;
    t_cmd            cmd;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign len     = lead_length(i_in_byte);

    // continuation check with second-byte limits
    always_comb begin
        ok = (i_in_byte & CONT_MASK) == CONT_TAG;
        if (r_cnt == 2'd1) begin
            if (r_exp == 3'd3) begin
                if (r_held[0] == LEAD_E0 && i_in_byte < SURR_LIMIT) ok = 1'b0;
                if (r_held[0] == LEAD_ED && i_in_byte >= SURR_LIMIT) ok = 1'b0;
            end else if (r_exp == 3'd4) begin
                if (r_held[0] == LEAD_F0 && i_in_byte < PLANE_LIMIT) ok = 1'b0;
                if (r_held[0] == LEAD_F4 && i_in_byte >= PLANE_LIMIT) ok = 1'b0;
            end
        end
    end

    assign complete = ({1'b0, r_cnt} + 3'd1) >= r_exp;

    // build command and next held state
    always_comb begin
        cmd.held    = r_held;
        cmd.pfx_n   = 2'd0;
        cmd.pfx_esc = 1'b0;
        cmd.b       = i_in_byte;
        cmd.bmode   = B_NONE;
        cmd.eos     = i_end_of_string;
        n_cnt       = r_cnt;
        n_exp       = r_exp;
        hold_we     = 1'b0;
        hold_idx    = r_cnt;
        take_idle   = 1'b0;

        if (r_cnt == 2'd0) begin
            take_idle = 1'b1;
        end else if (ok) begin
            if (complete) begin
                cmd.pfx_n = r_cnt;
                cmd.bmode = B_PASS;
                n_cnt     = 2'd0;
                n_exp     = 3'd0;
            end else if (i_end_of_string) begin
                cmd.pfx_n   = r_cnt;
                cmd.pfx_esc = 1'b1;
                cmd.bmode   = B_ESC;
                n_cnt       = 2'd0;
                n_exp       = 3'd0;
            end else begin
                hold_we = 1'b1;
                n_cnt   = r_cnt + 2'd1;
            end
        end else begin
            // broken sequence: escape what is held, then treat byte as fresh
            cmd.pfx_n   = r_cnt;
            cmd.pfx_esc = 1'b1;
            n_cnt       = 2'd0;
            n_exp       = 3'd0;
            take_idle   = 1'b1;
        end

        if (take_idle) begin
            if (i_in_byte < CTRL_LIMIT) begin
                cmd.bmode = B_ESC;
            end else if (i_in_byte < ASCII_LIMIT) begin
                cmd.bmode = B_PASS;
            end else if (len >= 3'd2) begin
                if (i_end_of_string) begin
                    cmd.bmode = B_ESC;
                end else begin
                    hold_we  = 1'b1;
                    hold_idx = 2'd0;
                    n_cnt    = 2'd1;
                    n_exp    = len;
                end
            end else begin
                cmd.bmode = B_ESC;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.pfx_n != 2'd0 || cmd.bmode != B_NONE);

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_exp <= 3'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
        end
    end

    // held bytes, no reset
    always_ff @(posedge i_clk) begin
        if (accept && hold_we) begin
            r_held[hold_idx] <= i_in_byte;
        end
    end

endmodule

/* src/u8ve_queue.sv */
// Small command queue between front and back.
module u8ve_queue #(
    parameter int DEPTH = u8ve_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  u8ve_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output u8ve_pkg::t_cmd o_data
);
    import u8ve_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;

    assign o_full     = r_cnt == CW'(DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_data     = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= n_wr;
            if (i_pop)  r_rd <= n_rd;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* src/u8ve_back.sv */
// Back end: expands command words into output bytes, one per cycle while i_stall is low.
module u8ve_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_nonempty,
    input  u8ve_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_string_done
);
    import u8ve_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;
    logic [1:0] r_slot;
    logic [1:0] r_char;

    logic       load;
    logic       in_pfx;
    logic [7:0] op_byte;
    logic       op_esc;
    logic       op_last;
    logic       char_last;
    logic [7:0] cur_byte;

    // current operation within the head command
    always_comb begin
        in_pfx  = r_slot < i_cmd.pfx_n;
        op_byte = in_pfx ? i_cmd.held[r_slot] : i_cmd.b;
        op_esc  = in_pfx ? i_cmd.pfx_esc : (i_cmd.bmode == B_ESC);
        op_last = (i_cmd.bmode != B_NONE) ? (r_slot == i_cmd.pfx_n)
                                          : (r_slot == 2'(i_cmd.pfx_n - 2'd1));
        char_last = !op_esc || (r_char == ESC_LO);
    end

    // character select
    always_comb begin
        if (!op_esc) begin
            cur_byte = op_byte;
        end else begin
            unique case (r_char)
                ESC_BSLASH: cur_byte = CHR_BSLASH;
                ESC_X:      cur_byte = CHR_X;
                ESC_HI:     cur_byte = hex_char(op_byte[7:4]);
                ESC_LO:     cur_byte = hex_char(op_byte[3:0] & NIBBLE_MASK);
                default:    cur_byte = CHR_BSLASH;
            endcase
        end
    end

    assign load  = !r_valid || !i_stall;
    assign o_pop = load && i_q_nonempty && op_last && char_last;

    // output register and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= 2'd0;
            r_char  <= 2'd0;
        end else if (load) begin
            r_valid <= i_q_nonempty;
            if (i_q_nonempty) begin
                if (char_last) begin
                    r_char <= 2'd0;
                    r_slot <= op_last ? 2'd0 : r_slot + 2'd1;
                end else begin
                    r_char <= r_char + 2'd1;
                end
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && i_q_nonempty) begin
            r_byte <= cur_byte;
            r_last <= op_last && char_last;
            r_done <= op_last && char_last && i_cmd.eos;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_last;
    assign o_string_done = r_done;

endmodule

/* src/utf8_validate_escape.sv */
// Top level of the UTF-8 validate-and-escape block.
// Input channel: i_valid / o_stall carry one string byte per word with an
// end-of-string flag. Output channel: o_valid / i_stall carry one output byte
// per word, with run_last on the final byte caused by an input byte and
// string_done on the final byte of the string.
// ASCII bytes 0x20-0x7F pass as one byte; bytes below 0x20, bytes that cannot
// lead and bytes of a broken or unfinished sequence become a four-byte \xHH
// escape; a valid multi-byte sequence is held and released whole when its last byte arrives.
// Throughput: the output side sends one byte per cycle while i_stall is low.
// An input byte releases 1 output byte for ASCII, 4 for an escape, 0 while
// a sequence is being collected, up to 16 when a held sequence breaks.
// The front takes a byte each cycle while the command queue has room.
// Each command passes through the queue storage, then the output register.
// Reset clears the held-sequence count, the queue and the output valid flag.
// When the receiver stalls, the output word holds and the queue fills; once
// full, o_stall is raised towards the sender.
module utf8_validate_escape #(
    parameter int QUEUE_DEPTH = u8ve_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_done
);
    import u8ve_pkg::*;

    logic q_full;
    logic q_nonempty;
    logic push;
    logic pop;
    t_cmd cmd_in;
    t_cmd cmd_out;

    u8ve_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (cmd_in)
    );

    u8ve_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (cmd_in),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_nonempty (q_nonempty),
        .o_data     (cmd_out)
    );

    u8ve_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_nonempty  (q_nonempty),
        .i_cmd         (cmd_out),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule
